/* hdl/ra_pkg.sv */
// Shared types and constants for the rank assignment block.
`timescale 1ns / 1ps
`default_nettype none
package ra_pkg;

    localparam int VALUE_W = 32;
    localparam int RANK_W  = 6;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef struct packed {
        logic load_key;
        logic compare;
    } ra_ctl_t;

endpackage
`default_nettype wire

/* hdl/ra_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* hdl/ra_rank_unit.sv */
// Shared signed comparator and less-than counter for one rank.
`timescale 1ns / 1ps
`default_nettype none
module ra_rank_unit #(
    parameter int CNT_W = 7
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ra_pkg::ra_ctl_t  ctl,
    input  wire ra_pkg::value_t   rd_data,
    output logic      [CNT_W-1:0] less
);
    import ra_pkg::*;

    value_t           key_reg;
    logic [CNT_W-1:0] less_reg;
    logic [CNT_W-1:0] less_next;
    logic             lt;

    assign lt = rd_data < key_reg;

    always_comb
    begin
        less_next = less_reg;
        if (ctl.load_key)
        begin
            less_next = '0;
        end
        else if (ctl.compare && lt)
        begin
            less_next = less_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_key)
        begin
            key_reg <= rd_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            less_reg <= '0;
        end
        else
        begin
            less_reg <= less_next;
        end
    end

    assign less = less_reg;

endmodule
`default_nettype wire

/* hdl/rank_assignment.sv */
// Rank assignment: loads signed values, then emits each value's ascending rank.
// Loading accepts one value per cycle; the block is ready for the next at once.
// On the last value, each result takes a key fetch (FETCH, KEY), one RAM read per
// stored value through the single comparator (SCAN), then output (OUT), which
// waits for m_axis_tready before the next result starts.
// Reset (rst_n, asynchronous, active low) empties the set and clears overflow.
`timescale 1ns / 1ps
`default_nettype none
module rank_assignment #(
    parameter int MAX_ITEMS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // [31:0] value
    input  wire logic        s_axis_tlast,  // last_value
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [7:0]  m_axis_tdata,  // [5:0] rank, [7:6] zero
    output logic             m_axis_tlast,  // last_rank
    output logic             m_axis_tuser   // overflow
);
    import ra_pkg::*;

    localparam int ADDR_W = $clog2(MAX_ITEMS);
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITEMS);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FETCH = 3'd1;
    localparam logic [2:0] ST_KEY   = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [ADDR_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0]  j_reg, j_next;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [31:0]       rdata;
    ra_ctl_t           ctl;
    logic [CNT_W-1:0]  less;
    logic              s_xfer;
    logic              is_last;
    logic [CNT_W+RANK_W-1:0] rank_wide;

    assign s_xfer  = s_axis_tvalid && s_axis_tready;
    assign is_last = CNT_W'(k_reg) == (count_reg - CNT_W'(1));

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        k_next       = k_reg;
        j_next       = j_reg;
        we           = 1'b0;
        waddr        = count_reg[ADDR_W-1:0];
        raddr        = '0;
        ctl.load_key = 1'b0;
        ctl.compare  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_xfer)
                begin
                    if (count_reg < MAX_CNT)
                    begin
                        we         = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        k_next     = '0;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                raddr      = k_reg;
                state_next = ST_KEY;
            end
            ST_KEY:
            begin
                ctl.load_key = 1'b1;
                raddr        = '0;
                j_next       = CNT_W'(1);
                state_next   = ST_SCAN;
            end
            ST_SCAN:
            begin
                ctl.compare = 1'b1;
                if (j_reg == count_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    raddr  = j_reg[ADDR_W-1:0];
                    j_next = j_reg + CNT_W'(1);
                end
            end
            ST_OUT:
            begin
                if (m_axis_tready)
                begin
                    if (is_last)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + ADDR_W'(1);
                        state_next = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            k_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
        end
    end

    ra_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(MAX_ITEMS)
    ) u_store (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(s_axis_tdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    ra_rank_unit #(
        .CNT_W(CNT_W)
    ) u_rank (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .rd_data(value_t'(rdata)),
        .less   (less)
    );

    assign rank_wide     = {{RANK_W{1'b0}}, less};
    assign s_axis_tready = state_reg == ST_IDLE;
    assign m_axis_tvalid = state_reg == ST_OUT;
    assign m_axis_tdata  = {2'b00, rank_wide[RANK_W-1:0]};
    assign m_axis_tlast  = is_last;
    assign m_axis_tuser  = ovf_reg;

endmodule
`default_nettype wire
